[src/mexp_pkg.sv]
// package for the modular exponentiation block: sizes, register codes, sequencer states
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	// default operand width
	localparam int unsigned MEXP_WORD_BITS = 32;

	// register indexes on the configuration port
	typedef logic reg_idx_t;
	localparam reg_idx_t REG_MODULUS  = 1'b0;
	localparam reg_idx_t REG_EXPONENT = 1'b1;

	// register values after reset, cut to the operand width where used
	localparam logic [63:0] MODULUS_RESET  = 64'd899;
	localparam logic [63:0] EXPONENT_RESET = 64'd65537;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_NEXT,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} mexp_state_t;

endpackage

`default_nettype wire

[src/modular_exponentiation.sv]
// modular exponentiation top level: bit-serial square-and-multiply over a configured modulus
// usage
// - s_* channel: one item per base value, s_tdata = base_value in the low WORD_BITS bits
// - m_* channel: one item per base value, m_tdata = power_result in the low WORD_BITS bits
// - cfg port: cfg_we writes cfg_data into register cfg_index (0 modulus, 1 exponent)
//   at the clock edge; write only while no item is in flight
// - a modulus of zero stands for 2^WORD_BITS, so products simply wrap
// timing
// - a modular product works one multiplier bit per cycle through
//   a single shift-add-reduce unit (add, then compare against m and 2m)
// - the base is first reduced by the same unit
// - then per exponent bit up to the highest set one: a decision state, a multiply
//   where the bit is set, then the square
// - one item is worked at a time; s_tready is high only while the sequencer is idle
// reset and stall
// - arst_n clears the sequencer and the output valid flag, the modulus returns to 899
//   and the exponent to 65537
// - the result waits in an output register while the next item is accepted; a finished
//   item holds in the last state until the output register is free
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int unsigned WORD_BITS = MEXP_WORD_BITS,
	localparam int unsigned TDATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire reg_idx_t              cfg_index,
	input  wire logic [WORD_BITS-1:0]  cfg_data,
	// input items
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TDATA_BITS-1:0] s_tdata,   // [WORD_BITS-1:0] base_value
	// result items
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [TDATA_BITS-1:0]      m_tdata    // [WORD_BITS-1:0] power_result
);

	localparam int unsigned CW = $clog2(WORD_BITS);   // bit counter width
	localparam int unsigned MW = WORD_BITS + 1;       // modulus incl. 2^WORD_BITS
	localparam int unsigned XW = WORD_BITS + 2;       // partial sum, below 3m

	localparam logic [CW-1:0]        CNT_TOP = CW'(WORD_BITS - 1);
	localparam logic [WORD_BITS-1:0] ONE_W   = WORD_BITS'(1);

	// configuration registers
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] exponent_q;

	// sequencer
	mexp_state_t state_q, state_d;

	// datapath
	logic [WORD_BITS-1:0] acc_q;      // running partial product
	logic [WORD_BITS-1:0] mcand_q;    // value added in for each set multiplier bit
	logic [WORD_BITS-1:0] mplier_q;   // multiplier, shifted out msb first
	logic [WORD_BITS-1:0] res_q;      // running result
	logic [WORD_BITS-1:0] sq_q;       // running square of the base
	logic [WORD_BITS-1:0] exp_q;      // exponent, shifted out lsb first
	logic [CW-1:0]        cnt_q;      // multiplier bit counter

	// output register
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_data_q;

	// control
	logic cnt_last;
	logic out_free;
	logic load_out;

	// shift-add-reduce unit
	logic [MW-1:0]        mod_ext;
	logic [XW-1:0]        sum;
	logic [XW-1:0]        mod_x1;
	logic [XW-1:0]        mod_x2;
	logic [WORD_BITS-1:0] unit_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RESET[WORD_BITS-1:0];
			exponent_q <= EXPONENT_RESET[WORD_BITS-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
			endcase
		end
	end

	// zero modulus means 2^WORD_BITS
	assign mod_ext = (modulus_q == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus_q};

	// one step: 2*acc + bit*mcand, then bring back below m (sum < 3m)
	always_comb begin
		sum    = {1'b0, acc_q, 1'b0}
			+ (mplier_q[WORD_BITS-1] ? {2'b00, mcand_q} : {XW{1'b0}});
		mod_x1 = {1'b0, mod_ext};
		mod_x2 = {mod_ext, 1'b0};
		if (sum >= mod_x2) begin
			unit_out = WORD_BITS'(sum - mod_x2);
		end else if (sum >= mod_x1) begin
			unit_out = WORD_BITS'(sum - mod_x1);
		end else begin
			unit_out = sum[WORD_BITS-1:0];
		end
	end

	assign cnt_last = (cnt_q == '0);
	assign out_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_REDUCE;
			ST_REDUCE: if (cnt_last) state_d = ST_NEXT;
			ST_NEXT: begin
				if (exp_q == '0) begin
					state_d = ST_FINISH;
				end else if (exp_q[0]) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL:    if (cnt_last) state_d = ST_SQR;
			ST_SQR:    if (cnt_last) state_d = ST_NEXT;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_FINISH: load_out = out_free;
			default: begin
				s_tready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// reduce the base: shift its bits in, adding one for each set bit
				acc_q    <= '0;
				mcand_q  <= ONE_W;
				mplier_q <= s_tdata[WORD_BITS-1:0];
				cnt_q    <= CNT_TOP;
				res_q    <= ONE_W;
				exp_q    <= exponent_q;
			end
			ST_REDUCE: begin
				acc_q    <= unit_out;
				mplier_q <= mplier_q << 1;
				cnt_q    <= cnt_q - 1'b1;
				if (cnt_last) begin
					sq_q <= unit_out;
				end
			end
			ST_NEXT: begin
				acc_q    <= '0;
				mcand_q  <= sq_q;
				mplier_q <= exp_q[0] ? res_q : sq_q;
				cnt_q    <= CNT_TOP;
			end
			ST_MUL: begin
				if (cnt_last) begin
					// result done, square follows
					res_q    <= unit_out;
					acc_q    <= '0;
					mplier_q <= sq_q;
					cnt_q    <= CNT_TOP;
				end else begin
					acc_q    <= unit_out;
					mplier_q <= mplier_q << 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			ST_SQR: begin
				acc_q    <= unit_out;
				mplier_q <= mplier_q << 1;
				cnt_q    <= cnt_q - 1'b1;
				if (cnt_last) begin
					sq_q  <= unit_out;
					exp_q <= exp_q >> 1;
				end
			end
			ST_FINISH: begin
				acc_q <= acc_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_BITS'(out_data_q);

endmodule

`default_nettype wire

[verif/tb_modular_exponentiation.sv]
// self-checking testbench for the modular exponentiation block
`timescale 1ns / 1ps

module tb_modular_exponentiation;
	import mexp_pkg::*;

	localparam int W = MEXP_WORD_BITS;
	localparam int DATA_BITS = ((W + 7) / 8) * 8;
	// longest stretch without any item moving: one worst-case item, one long stall
	// on either side, taken several times over
	localparam int STALL_LIMIT = 30000;
	// quiet time after the last result, a bit more than one worst-case item
	localparam int TAIL_CYCLES = 2200;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 24;

	typedef logic [W-1:0] word_t;

	// one directed probe: register setting, base, and a typed-in power where obvious
	typedef struct packed {
		word_t modulus;
		word_t exponent;
		word_t base;
		logic  typed;
		word_t power;
	} probe_t;

	localparam int NUM_PROBES = 21;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	reg_idx_t             cfg_index;
	logic [W-1:0]         cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DATA_BITS-1:0] s_tdata;    // [W-1:0] base_value
	logic                 m_tvalid;
	logic                 m_tready = 1'b1;
	logic [DATA_BITS-1:0] m_tdata;    // [W-1:0] power_result

	// register copies kept by the predictor
	word_t pred_modulus  = MODULUS_RESET[W-1:0];
	word_t pred_exponent = EXPONENT_RESET[W-1:0];

	// powers still owed by the block, oldest first
	word_t pending_powers [$];
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	// when set, neither side idles
	bit no_idle = 1'b0;

	// directed probes: extremes, special cases, a small textbook rsa key
	probe_t probes [NUM_PROBES] = '{
		// reset setting, then exponent one
		'{32'd899, 32'd65537, 32'h0000_0000, 1'b1, 32'd0},
		'{32'd899, 32'd65537, 32'h0000_0001, 1'b1, 32'd1},
		'{32'd899, 32'd65537, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{32'd899, 32'd65537, 32'h0000_0002, 1'b0, 32'd0},
		'{32'd899, 32'd1,     32'd898,       1'b1, 32'd898},
		// zero exponent gives one
		'{32'd899, 32'd0,     32'd12345,     1'b1, 32'd1},
		// modulus one: one for a zero exponent, zero otherwise
		'{32'd1,   32'd0,     32'd7,         1'b1, 32'd1},
		'{32'd1,   32'd1,     32'd5,         1'b1, 32'd0},
		'{32'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
		// modulus zero wraps at the word width, then moduli that are powers of two
		'{32'd0,   32'd0,     32'h0000_0000, 1'b1, 32'd1},
		'{32'd0,   32'd1,     32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{32'd0,   32'd2,     32'hFFFF_FFFF, 1'b1, 32'd1},
		'{32'd0,   32'hFFFF_FFFF, 32'd3,     1'b0, 32'd0},
		'{32'd2,   32'd1,     32'hFFFF_FFFF, 1'b1, 32'd1},
		'{32'h8000_0000, 32'd3, 32'hFFFF_FFFF, 1'b0, 32'd0},
		// largest modulus: base equal to it reduces to zero, m-1 is minus one
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
		'{32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b0, 32'd0},
		// largest 32-bit prime, fermat exponent
		'{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'd2, 1'b0, 32'd0},
		// small rsa key, encrypt then decrypt
		'{32'd3233, 32'd17,   32'd65,        1'b0, 32'd0},
		'{32'd3233, 32'd2753, 32'd2790,      1'b0, 32'd0}
	};

	modular_exponentiation uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exact modular product, double-width before the reduction; zero modulus wraps
	function automatic word_t mul_mod(word_t a, word_t b, word_t m);
		logic [2*W-1:0] prod;
		prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
		if (m == '0)
			return prod[W-1:0];
		return word_t'(prod % {{W{1'b0}}, m});
	endfunction

	// base to the configured exponent, right-to-left square-and-multiply
	function automatic word_t expected_power(word_t base);
		word_t sq;
		word_t acc;
		sq = base;
		acc = word_t'(1);
		if (pred_modulus != '0)
			sq = base % pred_modulus;
		for (int i = 0; i < W; i++) begin
			if (pred_exponent[i])
				acc = mul_mod(acc, sq, pred_modulus);
			sq = mul_mod(sq, sq, pred_modulus);
		end
		return acc;
	endfunction

	// idle length for either side: mostly none or short, now and then very long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 40);
		return $urandom_range(200, 2500);
	endfunction

	// offer one base and hold it until taken; the owed power is booked at the handshake
	task automatic send_base(input word_t base, input word_t power);
		int unsigned gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_BITS'(base);
		do
			@(posedge clk);
		while (!s_tready);
		pending_powers.push_back(power);
		gap = idle_len();
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= DATA_BITS'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering and wait for every owed power, then let the sequencer settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input word_t value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODULUS)
			pred_modulus = value;
		else
			pred_exponent = value;
	endtask

	// result side: stretches of ready broken by stalls of random length
	always @(negedge clk) begin : ready_gen
		int unsigned hold;
		int unsigned stall;
		if (arst_n !== 1'b1) begin
			hold = 0;
		end else if (hold != 0) begin
			hold--;
		end else if (m_tready) begin
			stall = idle_len();
			if (stall != 0) begin
				m_tready <= 1'b0;
				hold = stall - 1;
			end
		end else begin
			m_tready <= 1'b1;
			hold = $urandom_range(0, 150);
		end
	end

	// result checker: each power against the oldest one owed
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid && m_tready) begin
			if (pending_powers.size() == 0) begin
				$error("power_result: none expected, got %h", m_tdata[W-1:0]);
				error_count++;
			end else begin : compare
				word_t want;
				want = pending_powers.pop_front();
				if (m_tdata[W-1:0] !== want) begin
					$error("power_result: expected %h, got %h", want, m_tdata[W-1:0]);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles where no item moves on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		word_t mod_pick;
		word_t exp_pick;
		word_t base;
		int unsigned r;

		// all inputs known from time zero while reset is held
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MODULUS;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part: rewrite only the registers that change between probes
		foreach (probes[i]) begin
			if (probes[i].modulus != pred_modulus ||
					probes[i].exponent != pred_exponent) begin
				drain();
				if (probes[i].modulus != pred_modulus)
					write_reg(REG_MODULUS, probes[i].modulus);
				if (probes[i].exponent != pred_exponent)
					write_reg(REG_EXPONENT, probes[i].exponent);
			end
			if (probes[i].typed)
				send_base(probes[i].base, probes[i].power);
			else
				send_base(probes[i].base, expected_power(probes[i].base));
		end

		// random part: a fresh register setting per phase, random bases within it
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case (ph == 0 ? 0 : $urandom_range(0, 5))
				0: mod_pick = $urandom;
				1: mod_pick = $urandom_range(1, 255);
				2: mod_pick = word_t'(1) << $urandom_range(0, W - 1);
				3: mod_pick = {1'b1, (W-1)'($urandom)};
				4: mod_pick = '0;
				default: mod_pick = '1 - $urandom_range(0, 15);
			endcase
			case (ph == 0 ? 0 : $urandom_range(0, 6))
				0: exp_pick = $urandom;
				1: exp_pick = $urandom_range(0, 15);
				2: exp_pick = word_t'(1) << $urandom_range(0, W - 1);
				3: exp_pick = '1;
				4: exp_pick = $urandom_range(0, 65535);
				5: exp_pick = '0;
				default: exp_pick = $urandom;
			endcase
			write_reg(REG_MODULUS, mod_pick);
			write_reg(REG_EXPONENT, exp_pick);
			// some phases run with no idling at all
			no_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					base = $urandom;
				else if (r < 70)
					base = $urandom_range(0, 3);
				else if (r < 80)
					// around the modulus, where reduction kicks in
					base = mod_pick + $urandom_range(0, 2) - 1;
				else if (r < 90)
					base = (mod_pick == '0) ? word_t'($urandom) : word_t'($urandom) % mod_pick;
				else
					base = '1 - $urandom_range(0, 3);
				send_base(base, expected_power(base));
			end
			no_idle = 1'b0;
		end

		// wind down: every owed power in, then a quiet stretch for strays
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_powers.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
src/mexp_pkg.sv
src/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
